// ===== rtl/mlcq_pkg.sv =====
package mlcq_pkg;

  localparam int NODES   = 256;
  localparam int LINES   = 4;
  localparam int NODE_W  = $clog2(NODES);
  localparam int CNT_W   = $clog2(NODES + 1);
  localparam int LINE_W  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = 9;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_UNGET = 2'd1;
  localparam logic [1:0] OP_GET   = 2'd2;
  localparam logic [1:0] OP_PEEK  = 2'd3;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_BAD_LINE  = 2'd1;
  localparam logic [1:0] ERR_POOL_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODES = 2'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  line;
    logic [31:0] chunk_addr;
    logic [30:0] chunk_len;
    logic [30:0] request_len;
  } req_t;

  typedef struct packed {
    logic [31:0] out_addr;
    logic [30:0] out_len;
    logic        head_ready;
    logic [30:0] head_len;
    logic [31:0] line_bytes;
    logic [8:0]  line_chunks;
    logic [8:0]  free_nodes;
    logic [1:0]  error_code;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic exe;
    logic ld;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic need_load;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/multi_line_chunk_queue_core.sv =====
// Chunk queue with up to four lines sharing a pool of 256 linked nodes.
// Input channel in_valid/in_ready/in_data carries one operation per beat:
// put at tail, unget at head, get from head or peek, on one line.
// Result channel out_valid/out_ready/out_data returns one beat per
// operation: the chunk taken by get, the head state of the line, its byte
// and chunk totals, the free node count and an error code.
// After accept an item passes through read, execute and write-back steps;
// a get that empties the head node of a line with more chunks adds a load
// step, for the dependent read of the next node's pointer and then its
// address and length in node memory. One item is in flight at a time. The
// result sits in an output register; a stalled receiver holds the block in
// its final step until the register frees up. Config port cfg_wr_en,
// cfg_index and cfg_data write the mode or node count; the user must write
// only while idle, which the block does not enforce. Either write empties
// all lines and rebuilds the pool. Reset (rst_n low, synchronous) sets
// mode 0, node count 256, all lines empty. Node memory needs no clearing
// pass: freed nodes are reused before a fill count hands out fresh ones.
module multi_line_chunk_queue_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mlcq_pkg::req_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mlcq_pkg::rsp_t                   out_data,
  input  logic                             cfg_wr_en,
  input  logic [mlcq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlcq_pkg::CFG_W-1:0]       cfg_data
);
  import mlcq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mlcq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  mlcq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_seq : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("beat accepted while busy");

  a_bad : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_code == ERR_BAD_LINE) |->
      (out_data.line_chunks == '0 && out_data.line_bytes == '0))
    else $error("bad line beat carries line state");

  a_rdy : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.head_ready) |-> (out_data.line_chunks != '0))
    else $error("head ready on empty line");

  a_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.free_nodes <= 9'(NODES) && out_data.line_chunks <= 9'(NODES)))
    else $error("count beyond pool size");

endmodule

// ===== rtl/mlcq_ctrl.sv =====
module mlcq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  mlcq_pkg::sts_t sts,
  output logic          in_ready,
  output mlcq_pkg::cmd_t cmd
);
  import mlcq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EXE  = 3'd2;
  localparam logic [2:0] S_LD   = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_nxt = S_EXE;
      end
      S_EXE: begin
        cmd.exe = 1'b1;
        state_nxt = sts.need_load ? S_LD : S_WB;
      end
      S_LD: begin
        cmd.ld = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        if (sts.out_free) begin
          cmd.wb = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/mlcq_dp.sv =====
module mlcq_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mlcq_pkg::cmd_t                   cmd,
  output mlcq_pkg::sts_t                   sts,
  input  mlcq_pkg::req_t                   in_data,
  input  logic                             cfg_wr_en,
  input  logic [mlcq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlcq_pkg::CFG_W-1:0]       cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mlcq_pkg::rsp_t                   out_data
);
  import mlcq_pkg::*;

  logic [NODE_W-1:0] next_mem [NODES];
  logic [31:0]       addr_mem [NODES];
  logic [31:0]       len_mem  [NODES];

  logic [NODE_W-1:0] next_q_r;
  logic [31:0]       rd_addr_r, rd_len_r;

  req_t              in_r;
  logic              mode_r;
  logic [CNT_W-1:0]  nc_r;
  logic [CNT_W-1:0]  pool_free_r, freed_cnt_r, fresh_r;
  logic [NODE_W-1:0] free_head_r;

  logic [NODE_W-1:0] head_r [LINES];
  logic [NODE_W-1:0] tail_r [LINES];
  logic [31:0]       ha_r [LINES];
  logic [31:0]       hl_r [LINES];
  logic [31:0]       ta_r [LINES];
  logic [31:0]       tl_r [LINES];
  logic [31:0]       bytes_r [LINES];
  logic [CNT_W-1:0]  chunks_r [LINES];

  logic [31:0] oaddr_r;
  logic [30:0] olen_r;
  logic [1:0]  err_r;
  logic        out_valid_r;
  rsp_t        out_r;

  logic [LINE_W-1:0] l;
  logic              bad, have, chunk_ok, is_pu;
  logic              tail_merge, head_merge, alloc, perr, pop, split, same;
  logic [NODE_W-1:0] hp, tp, take_n, next_rd;
  logic [31:0]       ha, hl, ta, tl, clen32, req32;
  logic              aw_en, nw_en;
  logic [NODE_W-1:0] aw_a, nw_a, nw_d;
  logic [31:0]       aw_addr, aw_len;
  logic [CNT_W-1:0]  cfg_nc;
  rsp_t              rsp;

  always_comb begin
    l        = in_r.line[LINE_W-1:0];
    bad      = (in_r.line >= 3'(LINES));
    hp       = head_r[l];
    tp       = tail_r[l];
    ha       = ha_r[l];
    hl       = hl_r[l];
    ta       = ta_r[l];
    tl       = tl_r[l];
    same     = (hp == tp);
    have     = (chunks_r[l] != '0);
    clen32   = {1'b0, in_r.chunk_len};
    req32    = {1'b0, in_r.request_len};
    chunk_ok = (in_r.chunk_addr != '0) && (in_r.chunk_len != '0);
    is_pu    = !bad && chunk_ok && ((in_r.opcode == OP_PUT) || (in_r.opcode == OP_UNGET));
    tail_merge = is_pu && (in_r.opcode == OP_PUT) && mode_r && have
                 && (ta + tl == in_r.chunk_addr);
    head_merge = is_pu && (in_r.opcode == OP_UNGET) && mode_r && have
                 && (in_r.chunk_addr + clen32 == ha);
    alloc    = is_pu && !tail_merge && !head_merge && (pool_free_r != '0);
    perr     = is_pu && !tail_merge && !head_merge && (pool_free_r == '0);
    take_n   = (freed_cnt_r != '0) ? free_head_r : fresh_r[NODE_W-1:0];
    pop      = !bad && (in_r.opcode == OP_GET) && have && (req32 >= hl);
    split    = !bad && (in_r.opcode == OP_GET) && have && !pop && mode_r;
    next_rd  = (in_r.opcode == OP_GET) ? hp : free_head_r;

    aw_en = cmd.exe && (tail_merge || head_merge || alloc || split);
    aw_a = hp;
    aw_addr = in_r.chunk_addr;
    aw_len = clen32;
    if (tail_merge) begin
      aw_a = tp;
      aw_addr = ta;
      aw_len = tl + clen32;
    end else if (head_merge) begin
      aw_len = hl + clen32;
    end else if (alloc) begin
      aw_a = take_n;
    end else begin
      aw_addr = ha + req32;
      aw_len = hl - req32;
    end

    nw_en = cmd.exe && ((alloc && ((in_r.opcode == OP_UNGET) || have)) || pop);
    nw_a = hp;
    nw_d = free_head_r;
    if (alloc && in_r.opcode == OP_PUT) begin
      nw_a = tp;
      nw_d = take_n;
    end else if (alloc) begin
      nw_a = take_n;
      nw_d = hp;
    end

    cfg_nc = cfg_data;
    if (cfg_data == '0) cfg_nc = CNT_W'(1);
    if (cfg_data > CNT_W'(NODES)) cfg_nc = CNT_W'(NODES);

    rsp = '0;
    rsp.free_nodes = 9'(pool_free_r);
    if (bad) begin
      rsp.error_code = ERR_BAD_LINE;
    end else begin
      rsp.out_addr    = oaddr_r;
      rsp.out_len     = olen_r;
      rsp.error_code  = err_r;
      rsp.line_bytes  = bytes_r[l];
      rsp.line_chunks = 9'(chunks_r[l]);
      if (have) begin
        rsp.head_len   = hl[30:0];
        rsp.head_ready = mode_r ? (hl >= req32) : (hl == req32);
      end
    end
  end

  assign sts.need_load = pop && (chunks_r[l] != CNT_W'(1));
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (nw_en) next_mem[nw_a] <= nw_d;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) next_q_r <= next_mem[next_rd];
    if (cmd.exe) begin
      rd_addr_r <= addr_mem[next_q_r];
      rd_len_r  <= len_mem[next_q_r];
    end
    if (aw_en) begin
      addr_mem[aw_a] <= aw_addr;
      len_mem[aw_a]  <= aw_len;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) in_r <= in_data;
    if (cmd.wb) out_r <= rsp;
    if (cmd.exe) begin
      err_r <= perr ? ERR_POOL_EMPTY : ERR_OK;
      if (pop) begin
        oaddr_r <= ha;
        olen_r  <= hl[30:0];
      end else if (split) begin
        oaddr_r <= ha;
        olen_r  <= in_r.request_len;
      end else begin
        oaddr_r <= '0;
        olen_r  <= '0;
      end
    end
    if (cmd.exe && !bad) begin
      if (tail_merge) begin
        tl_r[l] <= tl + clen32;
        if (same) hl_r[l] <= tl + clen32;
      end
      if (head_merge) begin
        ha_r[l] <= in_r.chunk_addr;
        hl_r[l] <= hl + clen32;
        if (same) begin
          ta_r[l] <= in_r.chunk_addr;
          tl_r[l] <= hl + clen32;
        end
      end
      if (alloc) begin
        if (in_r.opcode == OP_PUT || !have) begin
          tail_r[l] <= take_n;
          ta_r[l]   <= in_r.chunk_addr;
          tl_r[l]   <= clen32;
        end
        if (in_r.opcode == OP_UNGET || !have) begin
          head_r[l] <= take_n;
          ha_r[l]   <= in_r.chunk_addr;
          hl_r[l]   <= clen32;
        end
      end
      if (split) begin
        ha_r[l] <= ha + req32;
        hl_r[l] <= hl - req32;
        if (same) begin
          ta_r[l] <= ha + req32;
          tl_r[l] <= hl - req32;
        end
      end
      if (pop) head_r[l] <= next_q_r;
      if (alloc) begin
        if (freed_cnt_r != '0) free_head_r <= next_q_r;
      end
      if (pop) free_head_r <= hp;
    end
    if (cmd.ld) begin
      ha_r[l] <= rd_addr_r;
      hl_r[l] <= rd_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      nc_r        <= CNT_W'(NODES);
      pool_free_r <= CNT_W'(NODES);
      freed_cnt_r <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LINES; i++) begin
        chunks_r[i] <= '0;
        bytes_r[i]  <= '0;
      end
    end else begin
      if (cmd.wb) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en && (cfg_index == CFG_MODE || cfg_index == CFG_NODES)) begin
        if (cfg_index == CFG_MODE) begin
          mode_r <= cfg_data[0];
          pool_free_r <= nc_r;
        end else begin
          nc_r <= cfg_nc;
          pool_free_r <= cfg_nc;
        end
        freed_cnt_r <= '0;
        fresh_r     <= '0;
        for (int i = 0; i < LINES; i++) begin
          chunks_r[i] <= '0;
          bytes_r[i]  <= '0;
        end
      end else if (cmd.exe && !bad) begin
        if (tail_merge || head_merge) begin
          bytes_r[l] <= bytes_r[l] + clen32;
        end
        if (alloc) begin
          bytes_r[l]  <= bytes_r[l] + clen32;
          chunks_r[l] <= chunks_r[l] + CNT_W'(1);
          pool_free_r <= pool_free_r - CNT_W'(1);
          if (freed_cnt_r != '0) begin
            freed_cnt_r <= freed_cnt_r - CNT_W'(1);
          end else begin
            fresh_r <= fresh_r + CNT_W'(1);
          end
        end
        if (pop) begin
          bytes_r[l]  <= bytes_r[l] - hl;
          chunks_r[l] <= chunks_r[l] - CNT_W'(1);
          pool_free_r <= pool_free_r + CNT_W'(1);
          freed_cnt_r <= freed_cnt_r + CNT_W'(1);
        end
        if (split) begin
          bytes_r[l] <= bytes_r[l] - req32;
        end
      end
    end
  end

endmodule
